[design/tea_pkg.sv]
package tea_pkg;

    localparam int          ROUND_COUNT = 16;
    localparam logic [31:0] TEA_DELTA   = 32'h9e37_79b9;
    localparam int          WORD_W      = 32;
    localparam int          KEY_WORDS   = 4;
    localparam int          KEY_IDX_W   = $clog2(KEY_WORDS);

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_op;

    typedef enum logic [KEY_IDX_W-1:0] {
        KEY_W0 = 2'd0,
        KEY_W1 = 2'd1,
        KEY_W2 = 2'd2,
        KEY_W3 = 2'd3
    } t_key_idx;

    typedef struct packed {
        logic [WORD_W-1:0] k0;
        logic [WORD_W-1:0] k1;
        logic [WORD_W-1:0] k2;
        logic [WORD_W-1:0] k3;
    } t_key;

    // delta times n modulo 2^32, for elaboration-time constants
    function automatic logic [WORD_W-1:0] delta_sum(input int n);
        logic [63:0] prod;
        prod = 64'(TEA_DELTA) * 64'(n);
        return prod[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mix_half(
        input logic [WORD_W-1:0] v,
        input logic [WORD_W-1:0] sum,
        input logic [WORD_W-1:0] ka,
        input logic [WORD_W-1:0] kb
    );
        return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
    endfunction

endpackage

[design/tea_stage.sv]
module tea_stage #(
    parameter logic [tea_pkg::WORD_W-1:0] ENC_SUM = tea_pkg::TEA_DELTA,
    parameter logic [tea_pkg::WORD_W-1:0] DEC_SUM = tea_pkg::TEA_DELTA,
    parameter logic                       ENC_HI  = 1'b1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tea_pkg::t_key              i_key,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  tea_pkg::t_op               i_op,
    input  logic [tea_pkg::WORD_W-1:0] i_hi,
    input  logic [tea_pkg::WORD_W-1:0] i_lo,
    output logic                       o_valid,
    input  logic                       i_ready,
    output tea_pkg::t_op               o_op,
    output logic [tea_pkg::WORD_W-1:0] o_hi,
    output logic [tea_pkg::WORD_W-1:0] o_lo
);

    logic                       r_valid;
    tea_pkg::t_op               r_op;
    logic [tea_pkg::WORD_W-1:0] r_hi;
    logic [tea_pkg::WORD_W-1:0] r_lo;

    logic                       w_enc;
    logic                       w_upd_hi;
    logic [tea_pkg::WORD_W-1:0] w_sum;
    logic [tea_pkg::WORD_W-1:0] w_src;
    logic [tea_pkg::WORD_W-1:0] w_dst;
    logic [tea_pkg::WORD_W-1:0] w_ka;
    logic [tea_pkg::WORD_W-1:0] w_kb;
    logic [tea_pkg::WORD_W-1:0] w_mix;
    logic [tea_pkg::WORD_W-1:0] w_res;
    logic [tea_pkg::WORD_W-1:0] n_hi;
    logic [tea_pkg::WORD_W-1:0] n_lo;

    // decryption walks the half-rounds backwards, so it updates the other word
    always_comb begin
        w_enc    = (i_op == tea_pkg::OP_ENCRYPT);
        w_upd_hi = w_enc ? ENC_HI : ~ENC_HI;
        w_sum    = w_enc ? ENC_SUM : DEC_SUM;
        w_src    = w_upd_hi ? i_lo : i_hi;
        w_dst    = w_upd_hi ? i_hi : i_lo;
        w_ka     = w_upd_hi ? i_key.k0 : i_key.k2;
        w_kb     = w_upd_hi ? i_key.k1 : i_key.k3;
        w_mix    = tea_pkg::mix_half(w_src, w_sum, w_ka, w_kb);
        w_res    = w_enc ? (w_dst + w_mix) : (w_dst - w_mix);
        n_hi     = w_upd_hi ? w_res : i_hi;
        n_lo     = w_upd_hi ? i_lo : w_res;
    end

    // stage loads when empty or when its content moves on
    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_op <= i_op;
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_hi    = r_hi;
    assign o_lo    = r_lo;

endmodule

[design/tea_block_cipher_16_round_core.sv]
// tea block cipher core, reduced round count (16 by default)
//
// input channel: i_in_valid / o_in_ready with i_opcode (0 encrypt, 1 decrypt),
// i_block_high and i_block_low, the block as two big-endian words.
// output channel: o_out_valid / i_out_ready with o_out_high and o_out_low.
// key: four 32-bit words written through i_cfg_we / i_cfg_index / i_cfg_data,
// one word per cycle, no wait; write only while no item is in flight.
//
// every half-round (one word update) is one register stage, so the pipe is
// 2 * ROUND_COUNT stages deep; with the receiver ready, one item can be
// taken from the output every cycle. each stage holds its own valid bit and
// loads when empty or when its item moves on, so a stalled receiver only
// freezes the occupied stages; bubbles further up are squeezed out and the
// input keeps taking items until the pipe is full. nothing is dropped or
// repeated.
// reset empties the pipe and clears the key words to zero.
module tea_block_cipher_16_round_core #(
    parameter int ROUND_COUNT = tea_pkg::ROUND_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [tea_pkg::KEY_IDX_W-1:0] i_cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]    i_cfg_data,
    // input items
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [tea_pkg::WORD_W-1:0]    i_block_high,
    input  logic [tea_pkg::WORD_W-1:0]    i_block_low,
    // result items
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tea_pkg::WORD_W-1:0]    o_out_high,
    output logic [tea_pkg::WORD_W-1:0]    o_out_low
);

    localparam int STAGES = 2 * ROUND_COUNT;

    // key words
    tea_pkg::t_key r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
        end else if (i_cfg_we) begin
            case (tea_pkg::t_key_idx'(i_cfg_index))
                tea_pkg::KEY_W0: r_key.k0 <= i_cfg_data;
                tea_pkg::KEY_W1: r_key.k1 <= i_cfg_data;
                tea_pkg::KEY_W2: r_key.k2 <= i_cfg_data;
                tea_pkg::KEY_W3: r_key.k3 <= i_cfg_data;
                default:         r_key    <= r_key;
            endcase
        end
    end

    // pipe links: entry 0 is the input port, entry STAGES is the output
    logic                       w_vld [STAGES+1];
    logic                       w_rdy [STAGES+1];
    tea_pkg::t_op               w_op  [STAGES+1];
    logic [tea_pkg::WORD_W-1:0] w_hi  [STAGES+1];
    logic [tea_pkg::WORD_W-1:0] w_lo  [STAGES+1];

    assign w_vld[0]        = i_in_valid;
    assign w_op[0]         = tea_pkg::t_op'(i_opcode);
    assign w_hi[0]         = i_block_high;
    assign w_lo[0]         = i_block_low;
    assign o_in_ready      = w_rdy[0];
    assign w_rdy[STAGES]   = i_out_ready;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            // stage g is half of round g/2; encrypt uses sum delta*(r+1)
            // and updates the high word first, decrypt uses delta*(N-r)
            // and updates the low word first
            localparam int          RND     = g / 2;
            localparam logic [31:0] ENC_SUM = tea_pkg::delta_sum(RND + 1);
            localparam logic [31:0] DEC_SUM = tea_pkg::delta_sum(ROUND_COUNT - RND);
            localparam logic        ENC_HI  = ((g % 2) == 0);

            tea_stage #(
                .ENC_SUM (ENC_SUM),
                .DEC_SUM (DEC_SUM),
                .ENC_HI  (ENC_HI)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_key   (r_key),
                .i_valid (w_vld[g]),
                .o_ready (w_rdy[g]),
                .i_op    (w_op[g]),
                .i_hi    (w_hi[g]),
                .i_lo    (w_lo[g]),
                .o_valid (w_vld[g+1]),
                .i_ready (w_rdy[g+1]),
                .o_op    (w_op[g+1]),
                .o_hi    (w_hi[g+1]),
                .o_lo    (w_lo[g+1])
            );
        end
    endgenerate

    // the last stage register is the output register
    assign o_out_valid = w_vld[STAGES];
    assign o_out_high  = w_hi[STAGES];
    assign o_out_low   = w_lo[STAGES];

    // an empty output stage lets every stage above it load
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output stage is empty");

    // an accepted item lands in the first stage
    a_accept_loads_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_vld[1])
        else $error("accepted item not captured by first stage");

    // a taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !w_vld[STAGES-1]) |=> !o_out_valid)
        else $error("result repeated on output");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // pipe depth: one register stage per half-round
    localparam int PIPE_LATENCY = 2 * tea_pkg::ROUND_COUNT;
    localparam int CYCLE_LIMIT  = 200000;

    // one 64-bit block as it leaves the core
    typedef struct packed {
        logic [tea_pkg::WORD_W-1:0] hi;
        logic [tea_pkg::WORD_W-1:0] lo;
    } t_block;

    // keeps its own copy of the key, predicts each block and checks results in order
    class tea_block_checker;
        tea_pkg::t_key key;
        t_block        pending_blocks[$];
        int            errors;

        function new();
            key    = '0;
            errors = 0;
        endfunction

        function void set_key_word(tea_pkg::t_key_idx idx, logic [tea_pkg::WORD_W-1:0] val);
            case (idx)
                tea_pkg::KEY_W0: key.k0 = val;
                tea_pkg::KEY_W1: key.k1 = val;
                tea_pkg::KEY_W2: key.k2 = val;
                tea_pkg::KEY_W3: key.k3 = val;
                default: ;
            endcase
        endfunction

        // one half-round mixing term, everything mod 2^32
        function logic [31:0] round_term(logic [31:0] v, logic [31:0] sum,
                                         logic [31:0] ka, logic [31:0] kb);
            return ((v << 4) + ka) ^ (v + sum) ^ ((v >> 5) + kb);
        endfunction

        function t_block tea_transform(tea_pkg::t_op op, logic [31:0] hi, logic [31:0] lo);
            logic [31:0] sum;
            t_block      res;
            if (op == tea_pkg::OP_ENCRYPT) begin
                sum = '0;
                for (int r = 0; r < tea_pkg::ROUND_COUNT; r++) begin
                    sum = sum + tea_pkg::TEA_DELTA;
                    hi  = hi + round_term(lo, sum, key.k0, key.k1);
                    lo  = lo + round_term(hi, sum, key.k2, key.k3);
                end
            end else begin
                // 32-bit product wraps like the hardware constant
                sum = tea_pkg::TEA_DELTA * 32'(tea_pkg::ROUND_COUNT);
                for (int r = 0; r < tea_pkg::ROUND_COUNT; r++) begin
                    lo  = lo - round_term(hi, sum, key.k2, key.k3);
                    hi  = hi - round_term(lo, sum, key.k0, key.k1);
                    sum = sum - tea_pkg::TEA_DELTA;
                end
            end
            res.hi = hi;
            res.lo = lo;
            return res;
        endfunction

        function int pending_count();
            return pending_blocks.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_block(tea_pkg::t_op op, logic [31:0] hi, logic [31:0] lo);
            pending_blocks.push_back(tea_transform(op, hi, lo));
        endfunction

        task check_block(logic [31:0] hi, logic [31:0] lo);
            t_block want;
            if (pending_blocks.size() == 0) begin
                report($sformatf("result %h_%h with no item pending", hi, lo));
            end else begin
                want = pending_blocks.pop_front();
                if (hi !== want.hi)
                    report($sformatf("out_high got %h want %h", hi, want.hi));
                if (lo !== want.lo)
                    report($sformatf("out_low got %h want %h", lo, want.lo));
            end
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [tea_pkg::KEY_IDX_W-1:0] i_cfg_index;
    logic [tea_pkg::WORD_W-1:0]    i_cfg_data;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_opcode;
    logic [tea_pkg::WORD_W-1:0]    i_block_high;
    logic [tea_pkg::WORD_W-1:0]    i_block_low;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic [tea_pkg::WORD_W-1:0]    o_out_high;
    logic [tea_pkg::WORD_W-1:0]    o_out_low;

    tea_block_checker sb = new();

    // idle rates in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;

    tea_block_cipher_16_round_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_block_high (i_block_high),
        .i_block_low  (i_block_low),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_high   (o_out_high),
        .o_out_low    (o_out_low)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: ready changes on the falling edge, random stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result items are taken at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_block(o_out_high, o_out_low);
    end

    // one key word through the write port, predictor follows
    task automatic write_key_word(tea_pkg::t_key_idx idx, logic [tea_pkg::WORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        sb.set_key_word(idx, val);
    endtask

    task automatic write_key(tea_pkg::t_key k);
        write_key_word(tea_pkg::KEY_W0, k.k0);
        write_key_word(tea_pkg::KEY_W1, k.k1);
        write_key_word(tea_pkg::KEY_W2, k.k2);
        write_key_word(tea_pkg::KEY_W3, k.k3);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = $urandom;
    endtask

    // present one item, with a random idle gap in front, and hold it until taken
    task automatic send_block(tea_pkg::t_op op, logic [31:0] hi, logic [31:0] lo);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_opcode     = op;
        i_block_high = hi;
        i_block_low  = lo;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_block(op, hi, lo);
    endtask

    // drop valid and wait until every pending block has come out
    task automatic drain_pipe();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    // random blocks, mostly full-range words with some corner words mixed in
    task automatic run_phase(int s_pct, int r_pct, int n_items, bit pause_midway);
        logic [31:0] hi;
        logic [31:0] lo;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < n_items; n++) begin
            hi = $urandom;
            lo = $urandom;
            case ($urandom_range(15))
                0: hi = '0;
                1: lo = '1;
                2: hi = 32'h8000_0000;
                default: ;
            endcase
            send_block(tea_pkg::t_op'($urandom_range(1)), hi, lo);
            // one full stop of the sender with the pipe draining behind it
            if (pause_midway && n == n_items / 2)
                drain_pipe();
        end
        drain_pipe();
        // margin before the next key change
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
    endtask

    initial begin
        t_block        ct;
        tea_pkg::t_key k;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = tea_pkg::KEY_W0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_opcode     = tea_pkg::OP_ENCRYPT;
        i_block_high = '0;
        i_block_low  = '0;

        // synchronous reset, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under the all-zero reset key
        send_idle_pct = 27;
        recv_idle_pct = 46;
        send_block(tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(tea_pkg::OP_DECRYPT, 32'h0000_0000, 32'h0000_0000);
        send_block(tea_pkg::OP_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(tea_pkg::OP_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
        send_block(tea_pkg::OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
        send_block(tea_pkg::OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);
        send_block(tea_pkg::OP_ENCRYPT, 32'haaaa_aaaa, 32'h5555_5555);
        send_block(tea_pkg::OP_DECRYPT, 32'h5555_5555, 32'haaaa_aaaa);
        send_block(tea_pkg::OP_ENCRYPT, 32'h0000_0000, 32'hffff_ffff);
        send_block(tea_pkg::OP_DECRYPT, 32'hffff_ffff, 32'h0000_0000);
        // round trip: decrypting a ciphertext must give the plaintext back
        ct = sb.tea_transform(tea_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(tea_pkg::OP_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
        send_block(tea_pkg::OP_DECRYPT, ct.hi, ct.lo);
        drain_pipe();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        // zero key, sender light idle, receiver heavy stall
        run_phase(27, 46, 80, 1'b0);

        // all-ones key
        write_key('1);
        run_phase(27, 46, 90, 1'b0);

        // random key, idle rates swapped, one full sender pause
        k = {$urandom, $urandom, $urandom, $urandom};
        write_key(k);
        run_phase(46, 27, 90, 1'b1);

        // alternating extreme words
        k = {32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
        write_key(k);
        run_phase(46, 27, 90, 1'b0);

        // random key at full rate, no idling on either side
        k = {$urandom, $urandom, $urandom, $urandom};
        write_key(k);
        run_phase(0, 0, 90, 1'b0);

        // back to an explicit zero key at full rate
        write_key('0);
        run_phase(0, 0, 90, 1'b0);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tea_pkg.sv
design/tea_stage.sv
design/tea_block_cipher_16_round_core.sv
verif/tb_top.sv
